@@ hw/rtl/lce_pkg.sv @@
// Package for the LFU cache engine: sizes, field types and codes.
// No dependencies; every other file imports it.
package lce_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OccW     = $clog2(CAPACITY + 1);
  localparam int unsigned CapW     = 5;
  localparam int unsigned CmpW     = (OccW > CapW) ? OccW : CapW;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned DatW     = 32;
  localparam int unsigned CntW     = 32;

  localparam logic [CapW-1:0]        CapReset  = 5'd16;
  localparam logic signed [DatW-1:0] MissValue = -32'sd1;

  // operation codes
  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  typedef struct packed {
    logic                   func;
    logic signed [KeyW-1:0] key;
    logic signed [DatW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic signed [DatW-1:0] read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } rsp_t;

  // one entry as seen at the scan read port
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic signed [DatW-1:0] data;
    logic [CntW-1:0]        count;
    logic [IdxW-1:0]        rank;
  } ent_t;

  // end-of-operation write into the entry store
  typedef struct packed {
    logic                   we;
    logic [IdxW-1:0]        idx;
    logic signed [KeyW-1:0] key;
    logic signed [DatW-1:0] data;
    logic [CntW-1:0]        count;
    logic [IdxW-1:0]        rank;
    logic                   unlink;
    logic [IdxW-1:0]        unlink_rank;
  } cmt_t;

endpackage

@@ hw/rtl/lce_entry_store.sv @@
// Entry store of the LFU cache engine: valid bits, keys, values, counts, ranks.
// Depends on lce_pkg.
module lce_entry_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [lce_pkg::IdxW-1:0] rd_idx_i,
  output lce_pkg::ent_t        ent_o,
  input  lce_pkg::cmt_t        cmt_i
);
  import lce_pkg::*;

  logic                   valid_q [CAPACITY];
  logic signed [KeyW-1:0] key_q   [CAPACITY];
  logic signed [DatW-1:0] data_q  [CAPACITY];
  logic [CntW-1:0]        count_q [CAPACITY];
  logic [IdxW-1:0]        rank_q  [CAPACITY];

  // single scan read port
  assign ent_o.valid = valid_q[rd_idx_i];
  assign ent_o.key   = key_q[rd_idx_i];
  assign ent_o.data  = data_q[rd_idx_i];
  assign ent_o.count = count_q[rd_idx_i];
  assign ent_o.rank  = rank_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CAPACITY; j++) begin
        valid_q[j] <= 1'b0;
      end
    end else if (cmt_i.we) begin
      valid_q[cmt_i.idx] <= 1'b1;
    end
  end

  // target write plus rank closing of the gap left by the target's old rank
  always_ff @(posedge clk_i) begin
    if (cmt_i.we) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (IdxW'(j) == cmt_i.idx) begin
          key_q[j]   <= cmt_i.key;
          data_q[j]  <= cmt_i.data;
          count_q[j] <= cmt_i.count;
          rank_q[j]  <= cmt_i.rank;
        end else if (cmt_i.unlink && valid_q[j] && (rank_q[j] > cmt_i.unlink_rank)) begin
          rank_q[j] <= rank_q[j] - 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/lce_scan_ctrl.sv @@
// Sequencer of the LFU cache engine: entry scan, hit/victim/free tracking, commit.
// Depends on lce_pkg.
module lce_scan_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lce_pkg::req_t            in_data_i,
  input  logic [lce_pkg::OccW-1:0] cap_i,
  input  logic                     out_space_i,
  output logic                     rsp_load_o,
  output lce_pkg::rsp_t            rsp_o,
  output logic [lce_pkg::IdxW-1:0] rd_idx_o,
  input  lce_pkg::ent_t            ent_i,
  output lce_pkg::cmt_t            cmt_o
);
  import lce_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_e;

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [OccW-1:0]        occ_q, occ_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic signed [DatW-1:0] hit_data_q, hit_data_d;
  logic [CntW-1:0]        hit_count_q, hit_count_d;
  logic [IdxW-1:0]        hit_rank_q, hit_rank_d;
  logic                   vic_found_q, vic_found_d;
  logic [IdxW-1:0]        vic_idx_q, vic_idx_d;
  logic signed [KeyW-1:0] vic_key_q, vic_key_d;
  logic [CntW-1:0]        vic_count_q, vic_count_d;
  logic [IdxW-1:0]        vic_rank_q, vic_rank_d;
  logic                   free_found_q, free_found_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;

  logic [CntW-1:0] touch_count;
  logic [IdxW-1:0] top_rank;
  logic            full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign rd_idx_o    = idx_q;
  assign touch_count = (&hit_count_q) ? hit_count_q : hit_count_q + 1'b1;
  assign top_rank    = IdxW'(occ_q - 1'b1);
  assign full        = (occ_q >= cap_i);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    idx_d        = idx_q;
    occ_d        = occ_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_data_d   = hit_data_q;
    hit_count_d  = hit_count_q;
    hit_rank_d   = hit_rank_q;
    vic_found_d  = vic_found_q;
    vic_idx_d    = vic_idx_q;
    vic_key_d    = vic_key_q;
    vic_count_d  = vic_count_q;
    vic_rank_d   = vic_rank_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    cmt_o        = '0;
    rsp_o        = '0;
    rsp_load_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_data_i;
          idx_d        = '0;
          hit_d        = 1'b0;
          vic_found_d  = 1'b0;
          free_found_d = 1'b0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ent_i.valid && (ent_i.key == req_q.key)) begin
          hit_d       = 1'b1;
          hit_idx_d   = idx_q;
          hit_data_d  = ent_i.data;
          hit_count_d = ent_i.count;
          hit_rank_d  = ent_i.rank;
        end
        // lowest count wins, older rank breaks ties
        if (ent_i.valid && (!vic_found_q || (ent_i.count < vic_count_q) ||
            ((ent_i.count == vic_count_q) && (ent_i.rank < vic_rank_q)))) begin
          vic_found_d = 1'b1;
          vic_idx_d   = idx_q;
          vic_key_d   = ent_i.key;
          vic_count_d = ent_i.count;
          vic_rank_d  = ent_i.rank;
        end
        if (!ent_i.valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (idx_q == IdxW'(CAPACITY - 1)) begin
          state_d = S_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_COMMIT: begin
        if (out_space_i) begin
          rsp_load_o = 1'b1;
          rsp_o.hit  = hit_q;
          state_d    = S_IDLE;
          if (req_q.func == FuncGet) begin
            if (hit_q) begin
              cmt_o.we          = 1'b1;
              cmt_o.idx         = hit_idx_q;
              cmt_o.key         = req_q.key;
              cmt_o.data        = hit_data_q;
              cmt_o.count       = touch_count;
              cmt_o.rank        = top_rank;
              cmt_o.unlink      = 1'b1;
              cmt_o.unlink_rank = hit_rank_q;
              rsp_o.read_value  = hit_data_q;
            end else begin
              rsp_o.read_value = MissValue;
            end
          end else if (cap_i != '0) begin
            if (hit_q) begin
              cmt_o.we          = 1'b1;
              cmt_o.idx         = hit_idx_q;
              cmt_o.key         = req_q.key;
              cmt_o.data        = req_q.value;
              cmt_o.count       = touch_count;
              cmt_o.rank        = top_rank;
              cmt_o.unlink      = 1'b1;
              cmt_o.unlink_rank = hit_rank_q;
            end else if (full && vic_found_q) begin
              // evict and refill the same slot; occupancy unchanged
              cmt_o.we          = 1'b1;
              cmt_o.idx         = vic_idx_q;
              cmt_o.key         = req_q.key;
              cmt_o.data        = req_q.value;
              cmt_o.count       = CntW'(1);
              cmt_o.rank        = top_rank;
              cmt_o.unlink      = 1'b1;
              cmt_o.unlink_rank = vic_rank_q;
              rsp_o.evicted     = 1'b1;
              rsp_o.evicted_key = vic_key_q;
            end else if (free_found_q) begin
              cmt_o.we    = 1'b1;
              cmt_o.idx   = free_idx_q;
              cmt_o.key   = req_q.key;
              cmt_o.data  = req_q.value;
              cmt_o.count = CntW'(1);
              cmt_o.rank  = IdxW'(occ_q);
              occ_d       = occ_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      idx_q        <= idx_d;
      hit_q        <= hit_d;
      vic_found_q  <= vic_found_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    hit_idx_q   <= hit_idx_d;
    hit_data_q  <= hit_data_d;
    hit_count_q <= hit_count_d;
    hit_rank_q  <= hit_rank_d;
    vic_idx_q   <= vic_idx_d;
    vic_key_q   <= vic_key_d;
    vic_count_q <= vic_count_d;
    vic_rank_q  <= vic_rank_d;
    free_idx_q  <= free_idx_d;
  end

endmodule

@@ hw/rtl/lfu_cache_engine_top.sv @@
// LFU cache engine top level; depends on lce_pkg, lce_entry_store and lce_scan_ctrl.
// Key-value cache of CAPACITY entries (16) with least-frequently-used replacement,
// least-recent entry losing among equal use counts. Each request transaction
// (get or put) is accepted, then the entry store is scanned entry by entry
// through its single read port (key match, victim search and first free slot in
// one pass), and the commit step writes the entry update and loads the
// result register. in_ready_o is low from acceptance until commit. The result
// register frees the pipeline: the next request is taken while a result still
// waits for out_ready_i; commit waits only if the previous result is still held.
// capacity_in_use (cfg_data_i, reset 16) is clipped to CAPACITY and should only
// be written while idle; zero makes puts no-ops, while gets still read entries.
// Use counts saturate at all ones. No clearing pass is needed after reset.
module lfu_cache_engine_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lce_pkg::req_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lce_pkg::rsp_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lce_pkg::CapW-1:0]  cfg_data_i
);
  import lce_pkg::*;

  // configuration register
  logic [CapW-1:0] cap_q;
  logic [CmpW-1:0] cap_ext;
  logic [OccW-1:0] cap_sat;

  // result register
  logic out_valid_q, out_valid_d;
  rsp_t rsp_q;

  logic            out_space;
  logic            rsp_load;
  rsp_t            rsp;
  logic [IdxW-1:0] rd_idx;
  ent_t            ent;
  cmt_t            cmt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // clip to the physical entry count
  assign cap_ext = CmpW'(cap_q);
  assign cap_sat = (cap_ext > CmpW'(CAPACITY)) ? OccW'(CAPACITY) : OccW'(cap_ext);

  lce_scan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cap_i       (cap_sat),
    .out_space_i (out_space),
    .rsp_load_o  (rsp_load),
    .rsp_o       (rsp),
    .rd_idx_o    (rd_idx),
    .ent_i       (ent),
    .cmt_o       (cmt)
  );

  lce_entry_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .ent_o    (ent),
    .cmt_i    (cmt)
  );

  // result register: loaded at commit, emptied by the output transaction
  assign out_space = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

`ifndef SYNTHESIS
  // busy through the scan once a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a scan is running");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted))
    else $error("hit reported together with eviction");

  // commit only happens while not accepting
  a_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt.we |-> (rsp_load && !in_ready_o))
    else $error("entry write outside commit");
`endif

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for lfu_cache_engine_top: directed and random get/put traffic.
// Depends on lce_pkg and the engine RTL; the scoreboard class keeps its own cache
// image (LFU eviction, least recent among equal counts) and checks every result.
`timescale 1ns / 1ps

class lfu_scoreboard;

  bit                               ent_valid [lce_pkg::CAPACITY];
  logic signed [lce_pkg::KeyW-1:0]  ent_key   [lce_pkg::CAPACITY];
  logic signed [lce_pkg::DatW-1:0]  ent_data  [lce_pkg::CAPACITY];
  logic [lce_pkg::CntW-1:0]         ent_count [lce_pkg::CAPACITY];
  int unsigned                      ent_rank  [lce_pkg::CAPACITY];
  int unsigned                      occupancy;
  logic [lce_pkg::CapW-1:0]         capacity;

  lce_pkg::rsp_t expected_rsp_q [$];
  int unsigned   error_count, checked_count;
  int unsigned   get_count, put_count, hit_count, evict_count;

  function new();
    for (int i = 0; i < lce_pkg::CAPACITY; i++) begin
      ent_valid[i] = 1'b0;
    end
    occupancy = 0;
    capacity  = lce_pkg::CapReset;
  endfunction

  function void set_capacity(logic [lce_pkg::CapW-1:0] cap);
    capacity = cap;
  endfunction

  function int find_entry(logic signed [lce_pkg::KeyW-1:0] key);
    for (int i = 0; i < lce_pkg::CAPACITY; i++) begin
      if (ent_valid[i] && ent_key[i] == key) return i;
    end
    return -1;
  endfunction

  // take entry out of the recency order; younger ones shift down
  function void drop_rank(int idx);
    for (int j = 0; j < lce_pkg::CAPACITY; j++) begin
      if (ent_valid[j] && j != idx && ent_rank[j] > ent_rank[idx]) ent_rank[j]--;
    end
  endfunction

  // one more use (saturating) and most recent
  function void bump_entry(int idx);
    if (ent_count[idx] != '1) ent_count[idx]++;
    drop_rank(idx);
    ent_rank[idx] = occupancy - 1;
  endfunction

  function int pick_victim();
    int v;
    v = -1;
    for (int i = 0; i < lce_pkg::CAPACITY; i++) begin
      if (ent_valid[i]) begin
        if (v < 0 || ent_count[i] < ent_count[v] ||
            (ent_count[i] == ent_count[v] && ent_rank[i] < ent_rank[v]))
          v = i;
      end
    end
    return v;
  endfunction

  function lce_pkg::rsp_t predict_access(lce_pkg::req_t req);
    lce_pkg::rsp_t rsp;
    int            idx, slot, victim;
    int unsigned   cap_eff;
    rsp     = '0;
    cap_eff = int'(capacity);
    if (cap_eff > lce_pkg::CAPACITY) cap_eff = lce_pkg::CAPACITY;
    idx     = find_entry(req.key);
    rsp.hit = (idx >= 0);
    if (req.func == lce_pkg::FuncGet) begin
      if (idx >= 0) begin
        bump_entry(idx);
        rsp.read_value = ent_data[idx];
      end else begin
        rsp.read_value = lce_pkg::MissValue;
      end
    end else if (cap_eff != 0) begin
      if (idx >= 0) begin
        ent_data[idx] = req.value;
        bump_entry(idx);
      end else begin
        slot = -1;
        if (occupancy >= cap_eff) begin
          victim = pick_victim();
          if (victim >= 0) begin
            rsp.evicted       = 1'b1;
            rsp.evicted_key   = ent_key[victim];
            drop_rank(victim);
            ent_valid[victim] = 1'b0;
            occupancy--;
            slot = victim;
          end
        end
        if (slot < 0) begin
          for (int j = lce_pkg::CAPACITY - 1; j >= 0; j--) begin
            if (!ent_valid[j]) slot = j;
          end
        end
        if (slot >= 0) begin
          ent_valid[slot] = 1'b1;
          ent_key[slot]   = req.key;
          ent_data[slot]  = req.value;
          ent_count[slot] = 1;
          ent_rank[slot]  = occupancy;
          occupancy++;
        end
      end
    end
    return rsp;
  endfunction

  function void note_request(lce_pkg::req_t req);
    lce_pkg::rsp_t rsp;
    rsp = predict_access(req);
    if (req.func == lce_pkg::FuncGet) get_count++; else put_count++;
    if (rsp.hit) hit_count++;
    if (rsp.evicted) evict_count++;
    expected_rsp_q.push_back(rsp);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function void check_response(lce_pkg::rsp_t rsp);
    lce_pkg::rsp_t exp_rsp;
    if (expected_rsp_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
      error_count++;
      return;
    end
    exp_rsp = expected_rsp_q.pop_front();
    checked_count++;
    compare_field("hit", 32'(exp_rsp.hit), 32'(rsp.hit));
    compare_field("read_value", exp_rsp.read_value, rsp.read_value);
    compare_field("evicted", 32'(exp_rsp.evicted), 32'(rsp.evicted));
    compare_field("evicted_key", exp_rsp.evicted_key, rsp.evicted_key);
  endfunction

  function bit finish_check();
    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d results still expected at end of run", $time,
               expected_rsp_q.size());
      error_count++;
    end
    return (error_count == 0);
  endfunction

endclass

module testbench;
  import lce_pkg::*;

  // no-transaction watchdog; must outlast the receiver hold-off by far
  localparam int unsigned StallLimit    = 3000;
  localparam int unsigned HoldoffCycles = 300;
  // settle time after the last result
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned PoolSize      = 24;

  localparam logic [31:0] CornerWords [4] = '{32'h0000_0000, 32'hffff_ffff,
                                               32'h8000_0000, 32'h7fff_ffff};

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  req_t              in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  rsp_t              out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CapW-1:0]   cfg_data_i;

  lfu_cache_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  lfu_scoreboard sb = new();

  // per-cycle idle odds in percent, changed by the main sequence
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          holdoff_req;
  bit          holdoff_done;
  int unsigned cfg_writes;
  int unsigned stall_cycles;
  logic [31:0] key_pool [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: every transaction is sampled at the edge that completes it.
  // Requests go into the predictor first, so a result can never beat its request.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
    if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
  end

  // Watchdog: ends the run if no channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  // During the hold-off the engine fills (one result held, one in flight)
  // and has to stall its request port.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req && !holdoff_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk_i);
        holdoff_done = 1'b1;
      end
      out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Offer one request; idle cycles before it are drawn per cycle.
  // valid stays up from one request to the next unless an idle cycle intervenes.
  task automatic send_request(input req_t req);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(input logic func, input logic [31:0] key, input logic [31:0] value);
    req_t req;
    req.func  = func;
    req.key   = key;
    req.value = value;
    send_request(req);
  endtask

  // Sender pause: hold off until every outstanding result is back.
  // One result per request, so an empty queue means the engine is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap[CapW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(cap[CapW-1:0]);
    cfg_writes++;
  endtask

  // Mostly keys from a small hot set so hits, updates and evictions are
  // common; the skewed pick gives low pool slots high use counts, which
  // makes the LFU choice and the recency tie break both matter.
  function automatic req_t random_request(int unsigned window);
    req_t        req;
    int unsigned pick;
    req.func = $urandom_range(1, 0) ? FuncPut : FuncGet;
    pick     = $urandom_range(99, 0);
    if (pick < 85)      req.key = key_pool[$urandom_range($urandom_range(window - 1, 0), 0)];
    else if (pick < 95) req.key = $urandom;
    else                req.key = CornerWords[$urandom_range(3, 0)];
    if ($urandom_range(19, 0) == 0) req.value = CornerWords[$urandom_range(3, 0)];
    else                            req.value = $urandom;
    return req;
  endfunction

  // One random phase at a given capacity. The hot set is a few entries
  // wider than the capacity so the cache keeps evicting.
  task automatic run_phase(input int unsigned cap, input int unsigned n_items,
                           input bit with_holdoff);
    int unsigned window;
    drain_results();
    write_capacity(cap);
    window = (cap == 0) ? 8 : ((cap > CAPACITY) ? CAPACITY : cap) + 5;
    if (with_holdoff) holdoff_req = 1'b1;
    repeat (n_items) begin
      if ($urandom_range(49, 0) == 0) key_pool[$urandom_range(PoolSize - 1, 0)] = $urandom;
      send_request(random_request(window));
    end
  endtask

  initial begin
    bit passed;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    tx_idle_pct  = 33;
    rx_idle_pct  = 66;
    holdoff_req  = 1'b0;
    cfg_writes   = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset capacity: miss on empty cache, extreme keys and
    // values, update of a present key, hits and a plain miss.
    issue(FuncGet, 32'h0000_0000, 32'h0000_0000);
    issue(FuncPut, 32'h7fff_ffff, 32'h8000_0000);
    issue(FuncPut, 32'h8000_0000, 32'h7fff_ffff);
    issue(FuncPut, 32'hffff_ffff, 32'hffff_ffff);
    issue(FuncPut, 32'h0000_0000, 32'h0000_0000);
    issue(FuncGet, 32'h7fff_ffff, 32'h0000_0000);
    issue(FuncGet, 32'h8000_0000, 32'hffff_ffff);
    issue(FuncPut, 32'hffff_ffff, 32'h1234_5678);
    issue(FuncGet, 32'hffff_ffff, 32'h0000_0000);
    issue(FuncGet, 32'h5555_5555, 32'h0000_0000);

    // Capacity lowered below occupancy: every new key evicts one entry;
    // the lowest count goes first, the least recent among equal counts.
    drain_results();
    write_capacity(2);
    issue(FuncPut, 32'h0000_aaaa, 32'h0000_0001);
    issue(FuncGet, 32'h0000_aaaa, 32'h0000_0000);
    issue(FuncPut, 32'h5555_0000, 32'h0000_0002);
    issue(FuncPut, 32'h0f0f_0f0f, 32'h0000_0003);
    issue(FuncGet, 32'h0f0f_0f0f, 32'h0000_0000);
    issue(FuncPut, 32'hf0f0_f0f0, 32'h0000_0004);

    // Capacity zero: puts change nothing but still report presence;
    // gets keep reading what is left.
    drain_results();
    write_capacity(0);
    issue(FuncPut, 32'h1111_1111, 32'hdead_beef);
    issue(FuncPut, 32'hf0f0_f0f0, 32'hcafe_f00d);
    issue(FuncGet, 32'hf0f0_f0f0, 32'h0000_0000);
    issue(FuncGet, 32'h1111_1111, 32'h0000_0000);

    // Capacity above CAPACITY: clipped to CAPACITY.
    drain_results();
    write_capacity(31);
    issue(FuncPut, 32'h2222_2222, 32'h0000_0005);
    issue(FuncGet, 32'h2222_2222, 32'h0000_0000);

    // Random phases: sender idles 33%, receiver 66%.
    run_phase(16, 300, 1'b0);
    run_phase(31, 100, 1'b0);
    // sender 66%, receiver 33%; capacity drops well below occupancy
    tx_idle_pct = 66;
    rx_idle_pct = 33;
    run_phase(3, 150, 1'b0);
    run_phase(1, 100, 1'b0);
    run_phase(0, 60, 1'b0);
    // no idling; one long receiver hold-off to back up the engine
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(8, 200, 1'b1);
    run_phase(16, 240, 1'b0);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d gets, %0d puts, %0d hits, %0d evictions",
             sb.get_count + sb.put_count, sb.get_count, sb.put_count,
             sb.hit_count, sb.evict_count);
    $display("%0d capacity writes (0, 1, 2, 3, 8, 16, 31), one %0d-cycle receiver hold-off",
             cfg_writes, HoldoffCycles);
    passed = sb.finish_check();
    if (passed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
